### hdl/apbt_pkg.sv
// ----------------------------------------------------------------------------
// apbt_pkg
// Shared types, widths and helpers for the affine point and bounds transform.
// ----------------------------------------------------------------------------
`default_nettype none

package apbt_pkg;

  localparam int unsigned COORD_W       = 32;
  localparam int unsigned COEF_W        = 32;
  localparam int unsigned PROD_W        = COORD_W + COEF_W;
  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_POINT  = 2'd0,
    KIND_VECTOR = 2'd1,
    KIND_BOX    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCALE_XX = 3'd0,
    REG_SHEAR_XY = 3'd1,
    REG_SHIFT_X  = 3'd2,
    REG_SHEAR_YX = 3'd3,
    REG_SCALE_YY = 3'd4,
    REG_SHIFT_Y  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [COEF_W-1:0]  scale_xx;
    logic signed [COEF_W-1:0]  shear_xy;
    logic signed [COORD_W-1:0] shift_x;
    logic signed [COEF_W-1:0]  shear_yx;
    logic signed [COEF_W-1:0]  scale_yy;
    logic signed [COORD_W-1:0] shift_y;
  } matrix_t;

  typedef struct packed {
    logic [1:0]                kind;
    logic signed [COORD_W-1:0] in_x_lo;
    logic signed [COORD_W-1:0] in_y_lo;
    logic signed [COORD_W-1:0] in_x_hi;
    logic signed [COORD_W-1:0] in_y_hi;
    logic                      box_finite;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] out_x_lo;
    logic signed [COORD_W-1:0] out_y_lo;
    logic signed [COORD_W-1:0] out_x_hi;
    logic signed [COORD_W-1:0] out_y_hi;
    logic                      saturated;
  } out_item_t;

  function automatic logic signed [COORD_W-1:0] smin(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a < b) ? a : b;
  endfunction

  function automatic logic signed [COORD_W-1:0] smax(input logic signed [COORD_W-1:0] a,
                                                     input logic signed [COORD_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

`default_nettype wire

### hdl/apbt_if.sv
// ----------------------------------------------------------------------------
// apbt_if
// Valid/ready stream channels for input items and result items.
// ----------------------------------------------------------------------------
`default_nettype none

interface apbt_in_if;
  logic                valid;
  logic                ready;
  apbt_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface apbt_out_if;
  logic                valid;
  logic                ready;
  apbt_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### hdl/apbt_cfg_regs.sv
// ----------------------------------------------------------------------------
// apbt_cfg_regs
// Coefficient and translation registers, reset to the identity transform.
// ----------------------------------------------------------------------------
`default_nettype none

module apbt_cfg_regs #(
  parameter int unsigned FRAC_BITS = apbt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [apbt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [apbt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  output apbt_pkg::matrix_t                     matrix_o
);

  localparam logic [apbt_pkg::COEF_W-1:0] UNITY = apbt_pkg::COEF_W'(1) << FRAC_BITS;

  apbt_pkg::matrix_t matrix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q.scale_xx <= UNITY;
      matrix_q.shear_xy <= '0;
      matrix_q.shift_x  <= '0;
      matrix_q.shear_yx <= '0;
      matrix_q.scale_yy <= UNITY;
      matrix_q.shift_y  <= '0;
    end else if (cfg_we_i) begin
      case (apbt_pkg::cfg_reg_e'(cfg_idx_i))
        apbt_pkg::REG_SCALE_XX: matrix_q.scale_xx <= cfg_wdata_i;
        apbt_pkg::REG_SHEAR_XY: matrix_q.shear_xy <= cfg_wdata_i;
        apbt_pkg::REG_SHIFT_X:  matrix_q.shift_x  <= cfg_wdata_i;
        apbt_pkg::REG_SHEAR_YX: matrix_q.shear_yx <= cfg_wdata_i;
        apbt_pkg::REG_SCALE_YY: matrix_q.scale_yy <= cfg_wdata_i;
        apbt_pkg::REG_SHIFT_Y:  matrix_q.shift_y  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign matrix_o = matrix_q;

endmodule

`default_nettype wire

### hdl/apbt_coord.sv
// ----------------------------------------------------------------------------
// apbt_coord
// One output coordinate: product sum, floor shift, translation and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module apbt_coord #(
  parameter int unsigned FRAC_BITS = apbt_pkg::FRAC_BITS_DEF
) (
  input  wire logic signed [apbt_pkg::PROD_W-1:0]  p_i,
  input  wire logic signed [apbt_pkg::PROD_W-1:0]  q_i,
  input  wire logic signed [apbt_pkg::COORD_W-1:0] shift_i,
  input  wire logic                                translate_i,
  output logic signed [apbt_pkg::COORD_W-1:0]      coord_o,
  output logic                                     sat_o
);

  localparam int unsigned PW = apbt_pkg::PROD_W;
  localparam int unsigned CW = apbt_pkg::COORD_W;
  localparam int unsigned SW = PW + 1 - FRAC_BITS;
  localparam int unsigned VW = SW + 1;

  logic signed [PW:0]           sum;
  logic signed [SW-1:0]         floor_v;
  logic signed [VW-1:0]         tr;
  logic signed [VW-1:0]         val;
  logic        [VW-CW:0]        upper;
  logic                         fits;

  assign sum     = {p_i[PW-1], p_i} + {q_i[PW-1], q_i};
  assign floor_v = sum[PW:FRAC_BITS];
  assign tr      = translate_i ? {{(VW-CW){shift_i[CW-1]}}, shift_i} : '0;
  assign val     = {floor_v[SW-1], floor_v} + tr;
  assign upper   = val[VW-1:CW-1];
  assign fits    = (&upper) | ~(|upper);

  always_comb begin
    if (fits) begin
      coord_o = val[CW-1:0];
    end else if (val[VW-1]) begin
      coord_o = {1'b1, {(CW-1){1'b0}}};
    end else begin
      coord_o = {1'b0, {(CW-1){1'b1}}};
    end
  end

  assign sat_o = ~fits;

endmodule

`default_nettype wire

### hdl/affine_point_bounds_transform.sv
// ----------------------------------------------------------------------------
// affine_point_bounds_transform
// 2x3 affine transform of points, vectors and axis-aligned boxes.
//
//   channel  dir  handshake          payload
//   in_i     in   valid/ready        kind, lo/hi corners, box_finite
//   out_o    out  valid/ready        lo/hi results, saturated
//   cfg      in   cfg_we_i, no wait  cfg_idx_i, cfg_wdata_i
//
// One item per cycle while the output is not stalled; four register stages, in order:
// input register, eight 32x32 multipliers, per-corner sum/shift/clamp,
// min/max into the result register.
// Reset clears all stage valid bits and loads the identity matrix.
// A stall at the output holds only the occupied stages; bubbles close up.
// ----------------------------------------------------------------------------
`default_nettype none

module affine_point_bounds_transform #(
  parameter int unsigned FRAC_BITS = apbt_pkg::FRAC_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  apbt_in_if.sink                               in_i,
  apbt_out_if.source                            out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [apbt_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [apbt_pkg::CFG_DATA_W-1:0]  cfg_wdata_i
);

  localparam int unsigned PW = apbt_pkg::PROD_W;
  localparam int unsigned CW = apbt_pkg::COORD_W;

  apbt_pkg::matrix_t   matrix;

  logic                v1_q, v2_q, v3_q, v4_q;
  logic                en1, en2, en3, en4;

  apbt_pkg::in_item_t  item1_q, item2_q, item3_q;

  logic signed [PW-1:0] p_axl_d, p_axh_d, p_byl_d, p_byh_d;
  logic signed [PW-1:0] p_cxl_d, p_cxh_d, p_dyl_d, p_dyh_d;
  logic signed [PW-1:0] p_axl_q, p_axh_q, p_byl_q, p_byh_q;
  logic signed [PW-1:0] p_cxl_q, p_cxh_q, p_dyl_q, p_dyh_q;

  logic signed [PW-1:0] xa [4];
  logic signed [PW-1:0] xb [4];
  logic signed [PW-1:0] ya [4];
  logic signed [PW-1:0] yb [4];

  logic                translate;
  logic signed [CW-1:0] cx_d [4];
  logic signed [CW-1:0] cy_d [4];
  logic        [3:0]   sx_d, sy_d;
  logic signed [CW-1:0] cx_q [4];
  logic signed [CW-1:0] cy_q [4];
  logic        [3:0]   csat_q;

  apbt_pkg::out_item_t out_d, out_q;

  apbt_cfg_regs #(
    .FRAC_BITS (FRAC_BITS)
  ) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .matrix_o    (matrix)
  );

  assign en4 = ~v4_q | out_o.ready;
  assign en3 = ~v3_q | en4;
  assign en2 = ~v2_q | en3;
  assign en1 = ~v1_q | en2;

  assign in_i.ready = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
    end
  end

  // input register
  always_ff @(posedge clk_i) begin
    if (en1 && in_i.valid) begin
      item1_q <= in_i.data;
    end
  end

  // products
  assign p_axl_d = matrix.scale_xx * item1_q.in_x_lo;
  assign p_axh_d = matrix.scale_xx * item1_q.in_x_hi;
  assign p_byl_d = matrix.shear_xy * item1_q.in_y_lo;
  assign p_byh_d = matrix.shear_xy * item1_q.in_y_hi;
  assign p_cxl_d = matrix.shear_yx * item1_q.in_x_lo;
  assign p_cxh_d = matrix.shear_yx * item1_q.in_x_hi;
  assign p_dyl_d = matrix.scale_yy * item1_q.in_y_lo;
  assign p_dyh_d = matrix.scale_yy * item1_q.in_y_hi;

  always_ff @(posedge clk_i) begin
    if (en2 && v1_q) begin
      item2_q <= item1_q;
      p_axl_q <= p_axl_d;
      p_axh_q <= p_axh_d;
      p_byl_q <= p_byl_d;
      p_byh_q <= p_byh_d;
      p_cxl_q <= p_cxl_d;
      p_cxh_q <= p_cxh_d;
      p_dyl_q <= p_dyl_d;
      p_dyh_q <= p_dyh_d;
    end
  end

  // corners: (xl,yl) (xl,yh) (xh,yh) (xh,yl)
  always_comb begin
    xa[0] = p_axl_q; xa[1] = p_axl_q; xa[2] = p_axh_q; xa[3] = p_axh_q;
    xb[0] = p_byl_q; xb[1] = p_byh_q; xb[2] = p_byh_q; xb[3] = p_byl_q;
    ya[0] = p_cxl_q; ya[1] = p_cxl_q; ya[2] = p_cxh_q; ya[3] = p_cxh_q;
    yb[0] = p_dyl_q; yb[1] = p_dyh_q; yb[2] = p_dyh_q; yb[3] = p_dyl_q;
  end

  assign translate = (item2_q.kind != apbt_pkg::KIND_VECTOR);

  for (genvar g = 0; g < 4; g++) begin : g_corner
    apbt_coord #(
      .FRAC_BITS (FRAC_BITS)
    ) u_x (
      .p_i         (xa[g]),
      .q_i         (xb[g]),
      .shift_i     (matrix.shift_x),
      .translate_i (translate),
      .coord_o     (cx_d[g]),
      .sat_o       (sx_d[g])
    );

    apbt_coord #(
      .FRAC_BITS (FRAC_BITS)
    ) u_y (
      .p_i         (ya[g]),
      .q_i         (yb[g]),
      .shift_i     (matrix.shift_y),
      .translate_i (translate),
      .coord_o     (cy_d[g]),
      .sat_o       (sy_d[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (en3 && v2_q) begin
      item3_q <= item2_q;
      cx_q    <= cx_d;
      cy_q    <= cy_d;
      csat_q  <= sx_d | sy_d;
    end
  end

  // into result register: box min/max, non-finite box copy, point/vector corner 0
  always_comb begin
    out_d = '0;
    case (item3_q.kind)
      apbt_pkg::KIND_BOX: begin
        if (item3_q.box_finite) begin
          out_d.out_x_lo  = apbt_pkg::smin(apbt_pkg::smin(cx_q[0], cx_q[1]),
                                           apbt_pkg::smin(cx_q[2], cx_q[3]));
          out_d.out_x_hi  = apbt_pkg::smax(apbt_pkg::smax(cx_q[0], cx_q[1]),
                                           apbt_pkg::smax(cx_q[2], cx_q[3]));
          out_d.out_y_lo  = apbt_pkg::smin(apbt_pkg::smin(cy_q[0], cy_q[1]),
                                           apbt_pkg::smin(cy_q[2], cy_q[3]));
          out_d.out_y_hi  = apbt_pkg::smax(apbt_pkg::smax(cy_q[0], cy_q[1]),
                                           apbt_pkg::smax(cy_q[2], cy_q[3]));
          out_d.saturated = |csat_q;
        end else begin
          out_d.out_x_lo  = item3_q.in_x_lo;
          out_d.out_y_lo  = item3_q.in_y_lo;
          out_d.out_x_hi  = item3_q.in_x_hi;
          out_d.out_y_hi  = item3_q.in_y_hi;
          out_d.saturated = 1'b0;
        end
      end
      default: begin
        out_d.out_x_lo  = cx_q[0];
        out_d.out_y_lo  = cy_q[0];
        out_d.saturated = csat_q[0];
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en4 && v3_q) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid = v4_q;
  assign out_o.data  = out_q;

`ifndef NO_ASSERTIONS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (v1_q && v2_q && v3_q && v4_q && !out_o.ready))
    else $error("input stalled with a free pipeline stage");

  a_point_hi_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && item3_q.kind != apbt_pkg::KIND_BOX)
    |=> (out_o.data.out_x_hi == '0 && out_o.data.out_y_hi == '0))
    else $error("point or vector result with non-zero upper fields");

  a_box_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && item3_q.kind == apbt_pkg::KIND_BOX && !item3_q.box_finite)
    |=> (!out_o.data.saturated && out_o.data.out_x_lo == $past(item3_q.in_x_lo)
         && out_o.data.out_y_hi == $past(item3_q.in_y_hi)))
    else $error("non-finite box not passed unchanged");

  a_box_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && en4 && item3_q.kind == apbt_pkg::KIND_BOX && item3_q.box_finite)
    |=> (out_o.data.out_x_lo <= out_o.data.out_x_hi
         && out_o.data.out_y_lo <= out_o.data.out_y_hi))
    else $error("transformed box minimum above maximum");
`endif

endmodule

`default_nettype wire
